>>> src/sra_pkg.sv
// Shared constants, types and ray geometry helpers for the sliding ray attack generator.
// No dependencies.
`default_nettype none
package sra_pkg;

  localparam int BoardBits = 64;
  localparam int RayLen    = 7;
  localparam int NumRays   = 4;

  localparam logic OpRook   = 1'b0;
  localparam logic OpBishop = 1'b1;

  localparam logic [1:0] StepNone = 2'd0;
  localparam logic [1:0] StepInc  = 2'd1;
  localparam logic [1:0] StepDec  = 2'd2;

  typedef logic [5:0]        sq_t;
  typedef logic [2:0]        line_pos_t;
  typedef logic [RayLen-1:0] line_t;
  typedef sq_t [RayLen-1:0]  ray_idx_t;
  typedef logic [1:0]        step_t;

  // rank step of ray r for a piece kind
  function automatic step_t rank_step(input logic op, input logic [1:0] ray);
    step_t s;
    s = StepNone;
    case ({op, ray})
      {OpRook, 2'd0}:   s = StepInc;
      {OpRook, 2'd1}:   s = StepDec;
      {OpBishop, 2'd0}: s = StepInc;
      {OpBishop, 2'd1}: s = StepDec;
      {OpBishop, 2'd2}: s = StepInc;
      {OpBishop, 2'd3}: s = StepDec;
      default:          s = StepNone;
    endcase
    return s;
  endfunction

  // file step of ray r for a piece kind
  function automatic step_t file_step(input logic op, input logic [1:0] ray);
    step_t s;
    s = StepNone;
    case ({op, ray})
      {OpRook, 2'd2}:   s = StepInc;
      {OpRook, 2'd3}:   s = StepDec;
      {OpBishop, 2'd0}: s = StepInc;
      {OpBishop, 2'd1}: s = StepInc;
      {OpBishop, 2'd2}: s = StepDec;
      {OpBishop, 2'd3}: s = StepDec;
      default:          s = StepNone;
    endcase
    return s;
  endfunction

  // coordinate k steps away; on board iff bits [4:3] are zero
  function automatic logic [4:0] coord(input line_pos_t base, input step_t step,
                                       input line_pos_t k);
    logic [4:0] c;
    c = {2'b00, base};
    case (step)
      StepInc: c = {2'b00, base} + {2'b00, k};
      StepDec: c = {2'b00, base} - {2'b00, k};
      default: c = {2'b00, base};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/sra_ray_scan.sv
// Blocker scan along one ray: marks squares up to and including the first occupied one.
// Depends on sra_pkg.
`default_nettype none
module sra_ray_scan
  import sra_pkg::*;
(
  input  line_t occ,
  input  line_t on_board,
  output line_t hit
);

  logic open;

  always_comb begin
    open = 1'b1;
    hit  = '0;
    for (int k = 0; k < RayLen; k++) begin
      hit[k] = open & on_board[k];
      open   = open & on_board[k] & ~occ[k];
    end
  end

endmodule
`default_nettype wire

>>> src/sliding_ray_attack_generator.sv
// Rook / bishop bitboard attack generator, four register stages.
// Stages in order: input capture, ray gather, per-ray blocker scan, output register.
// Throughput: one beat per cycle while not stalled; each stage holds under stall and bubbles collapse.
// Reset clears the stage valid bits only; payload registers are not reset.
// Depends on sra_pkg and sra_ray_scan.
`default_nettype none
module sliding_ray_attack_generator
  import sra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             stall,
  input  wire logic        operation,
  input  wire logic [5:0]  square,
  input  wire logic [63:0] occupancy,
  output logic             attacks_valid,
  input  wire logic        attacks_stall,
  output logic [63:0]      attacks
);

  // stage 1: input capture
  logic        v1;
  logic        op1;
  sq_t         sq1;
  logic [63:0] occ1;
  // stage 2: gathered ray lines
  logic        v2;
  line_t       line2  [NumRays];
  line_t       board2 [NumRays];
  ray_idx_t    idx2   [NumRays];
  // stage 3: per-ray hits
  logic        v3;
  line_t       hit3   [NumRays];
  ray_idx_t    idx3   [NumRays];
  // stage 4: output register
  logic        v4;

  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4  = !v4 || !attacks_stall;
  assign rdy3  = !v3 || rdy4;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;
  assign stall = !rdy1;

  assign attacks_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= valid;
    end
    if (rdy1 && valid) begin
      op1  <= operation;
      sq1  <= square;
      occ1 <= occupancy;
    end
  end

  line_t    line2_next  [NumRays];
  line_t    board2_next [NumRays];
  ray_idx_t idx2_next   [NumRays];

  always_comb begin
    logic [4:0] rc;
    logic [4:0] fc;
    for (int r = 0; r < NumRays; r++) begin
      line2_next[r]  = '0;
      board2_next[r] = '0;
      idx2_next[r]   = '0;
      for (int k = 0; k < RayLen; k++) begin
        rc = coord(sq1[5:3], rank_step(op1, 2'(r)), line_pos_t'(k + 1));
        fc = coord(sq1[2:0], file_step(op1, 2'(r)), line_pos_t'(k + 1));
        board2_next[r][k] = (rc[4:3] == 2'b00) && (fc[4:3] == 2'b00);
        idx2_next[r][k]   = {rc[2:0], fc[2:0]};
        line2_next[r][k]  = occ1[{rc[2:0], fc[2:0]}];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      line2  <= line2_next;
      board2 <= board2_next;
      idx2   <= idx2_next;
    end
  end

  line_t hit3_next [NumRays];

  for (genvar r = 0; r < NumRays; r++) begin : g_scan
    sra_ray_scan u_scan (
      .occ      (line2[r]),
      .on_board (board2[r]),
      .hit      (hit3_next[r])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      hit3 <= hit3_next;
      idx3 <= idx2;
    end
  end

  logic [63:0] attacks_next;

  always_comb begin
    attacks_next = '0;
    for (int r = 0; r < NumRays; r++) begin
      for (int k = 0; k < RayLen; k++) begin
        if (hit3[r][k]) begin
          attacks_next[idx3[r][k]] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4 && v3) begin
      attacks <= attacks_next;
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    valid && !stall |=> v1)
    else $error("accepted beat did not reach stage 1");

  a_stage2_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !rdy3 |=> v2 && $stable(idx2[0]) && $stable(line2[0]))
    else $error("stage 2 changed while blocked");

  a_stage3_moves: assert property (@(posedge clk) disable iff (rst)
    v3 && rdy4 |=> v4)
    else $error("stage 3 beat lost on advance");

  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    v4 && attacks_stall |=> v4)
    else $error("stalled result dropped");

endmodule
`default_nettype wire

>>> test/sliding_ray_attack_generator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for sliding_ray_attack_generator: rook and bishop ray fills.
// Driver and monitor are clocked blocks; expected maps come from a local ray walk.
// Depends on sra_pkg and the generator RTL.
module sliding_ray_attack_generator_test;
  import sra_pkg::*;

  localparam int  RandomProbes = 900;
  localparam int  CycleLimit   = 200000;
  localparam int  MaxReported  = 10;

  typedef struct packed {
    logic        kind;
    logic [5:0]  origin;
    logic [63:0] occupied;
  } probe_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic        operation = OpRook;
  logic [5:0]  square = '0;
  logic [63:0] occupancy = '0;
  logic        attacks_valid;
  logic        attacks_stall = 1'b0;
  logic [63:0] attacks;

  probe_t      pending_probes[$];
  logic [63:0] expected_maps[$];
  int          total_probes = 0;
  int          beats_sent = 0;
  int          rook_beats = 0;
  int          bishop_beats = 0;
  int          maps_checked = 0;
  int          mismatches = 0;
  int          cycles = 0;

  sliding_ray_attack_generator DUT (
    .clk(clk),
    .rst(rst),
    .valid(valid),
    .stall(stall),
    .operation(operation),
    .square(square),
    .occupancy(occupancy),
    .attacks_valid(attacks_valid),
    .attacks_stall(attacks_stall),
    .attacks(attacks)
  );

  always #4 clk = ~clk;

  // walk four rays from the origin, each stopping on its first occupied square
  function automatic logic [63:0] ray_fill(logic kind, logic [5:0] origin,
                                           logic [63:0] occupied);
    logic [63:0] hits;
    int          d, r, f, dr, df;
    bit          blocked;
    hits = '0;
    for (d = 0; d < 4; d++) begin
      if (kind == OpBishop) begin
        dr = d[0] ? -1 : 1;
        df = d[1] ? -1 : 1;
      end else begin
        dr = (d == 0) ? 1 : (d == 1) ? -1 : 0;
        df = (d == 2) ? 1 : (d == 3) ? -1 : 0;
      end
      r = int'(origin[5:3]) + dr;
      f = int'(origin[2:0]) + df;
      blocked = 1'b0;
      while (!blocked && r >= 0 && r <= 7 && f >= 0 && f <= 7) begin
        hits[r * 8 + f] = 1'b1;
        blocked = occupied[r * 8 + f];
        r += dr;
        f += df;
      end
    end
    return hits;
  endfunction

  function automatic logic [63:0] random_board();
    logic [63:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(4))
      0: return a & b & c;
      1: return a | b;
      2: return a & b;
      3: return ($urandom_range(3) == 0) ? 64'd0 : a & b & c & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  task automatic add_probe(logic kind, logic [5:0] origin, logic [63:0] occupied);
    pending_probes.push_back('{kind: kind, origin: origin, occupied: occupied});
    total_probes++;
  endtask

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both
  function automatic int idle_phase();
    if (total_probes == 0)
      return 0;
    return (beats_sent * 4) / total_probes;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (valid && !stall) begin
        expected_maps.push_back(ray_fill(operation, square, occupancy));
        if (operation == OpBishop)
          bishop_beats++;
        else
          rook_beats++;
        beats_sent++;
      end
      if (!valid || !stall) begin
        if (pending_probes.size() != 0 &&
            !((idle_phase() == 1 && $urandom_range(99) < 54) ||
              (idle_phase() == 3 && $urandom_range(99) < 11))) begin
          operation <= pending_probes[0].kind;
          square    <= pending_probes[0].origin;
          occupancy <= pending_probes[0].occupied;
          void'(pending_probes.pop_front());
          valid     <= 1'b1;
        end else begin
          valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (attacks_valid && !attacks_stall) begin
        if (expected_maps.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReported)
            $display("unexpected attack beat: attacks=%h", attacks);
        end else begin
          if (attacks !== expected_maps[0]) begin
            mismatches++;
            if (mismatches <= MaxReported)
              $display("attack map mismatch on beat %0d: expected %h, got %h",
                       maps_checked, expected_maps[0], attacks);
          end
          void'(expected_maps.pop_front());
          maps_checked++;
        end
      end
      attacks_stall <= (idle_phase() == 2 && $urandom_range(99) < 54) ||
                       (idle_phase() == 3 && $urandom_range(99) < 11);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d maps outstanding", cycles,
               expected_maps.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [63:0] edge_ring;
    int          k, s;
    edge_ring = 64'hFF81_8181_8181_81FF;
    for (k = 0; k < 2; k++) begin
      add_probe(k[0], 6'd0, 64'd0);
      add_probe(k[0], 6'd7, 64'd0);
      add_probe(k[0], 6'd56, 64'd0);
      add_probe(k[0], 6'd63, 64'd0);
      add_probe(k[0], 6'd27, 64'd0);
      add_probe(k[0], 6'd36, '1);
      add_probe(k[0], 6'd18, 64'd1 << 18);
      add_probe(k[0], 6'd0, ~64'd1);
      add_probe(k[0], 6'd27, edge_ring);
      add_probe(k[0], 6'd49, edge_ring);
    end
    for (k = 0; k < RandomProbes; k++) begin
      s = $urandom_range(63);
      add_probe(1'($urandom_range(1)), s[5:0], random_board());
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (beats_sent < total_probes)
      @(posedge clk);
    while (expected_maps.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d rook and %0d bishop beats, %0d attack maps checked",
             rook_beats, bishop_beats, maps_checked);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && expected_maps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
